/* rtl/core/xcss_pkg.sv */
// xcss_pkg: shared constants, types and helpers of the chroma saturation core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package xcss_pkg;
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 12;
   localparam int WHITE_BITS  = 15;
   localparam int QUO_BITS    = SAMPLE_BITS + FRAC_BITS + 1;

   // divider pipeline: quotient bits resolved per stage and stage count
   localparam int DIV_PER     = 4;
   localparam int DIV_STAGES  = (QUO_BITS + DIV_PER - 1) / DIV_PER;

   localparam logic [1:0] CSR_USE_PIXEL_WHITE = 2'd0;
   localparam logic [1:0] CSR_WHITE_X         = 2'd1;
   localparam logic [1:0] CSR_WHITE_Z         = 2'd2;

   localparam logic [WHITE_BITS-1:0] WHITE_X_RESET = 15'd3893;
   localparam logic [WHITE_BITS-1:0] WHITE_Z_RESET = 15'd4460;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   // one channel's divider pipeline payload
   typedef struct packed {
      logic                 zero_w;
      logic                 neg;
      logic [QUO_BITS-1:0]  rem;
      logic [QUO_BITS-1:0]  quo;
      logic [QUO_BITS-1:0]  num;
      logic [SAMPLE_BITS:0] den;
   } div_type;

   // clamp a wide signed value to the sample range
   function automatic sample_type sat_wide(input logic signed [63:0] v, output logic ovf);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      ovf = 1'b0;
      if (v > hi) begin
         ovf = 1'b1;
         sat_wide = hi[SAMPLE_BITS-1:0];
      end else if (v < lo) begin
         ovf = 1'b1;
         sat_wide = lo[SAMPLE_BITS-1:0];
      end else begin
         sat_wide = v[SAMPLE_BITS-1:0];
      end
   endfunction
endpackage
`default_nettype wire

/* rtl/core/xcss_div.sv */
// xcss_div: pipelined restoring divider, (c << FRAC_BITS) / w truncating toward zero
// depends on xcss_pkg
`timescale 1ns / 1ps
`default_nettype none
module xcss_div import xcss_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   input  wire sample_type in_num,
   input  wire sample_type in_den,
   output logic            out_valid,
   output logic            out_zero,
   output logic            out_ovf,
   output sample_type      out_quo
);
   localparam int STEPS = QUO_BITS;
   localparam int PER   = DIV_PER;
   localparam int NST   = DIV_STAGES;

   div_type     st_ff [NST+1];
   div_type     st_in [NST+1];
   logic [NST:0] vld_ff;

   always_comb begin
      div_type d;
      logic signed [SAMPLE_BITS:0] n17;
      logic signed [SAMPLE_BITS:0] d17;
      d = '0;
      n17 = {in_num[SAMPLE_BITS-1], in_num};
      d17 = {in_den[SAMPLE_BITS-1], in_den};
      d.zero_w = (in_den == '0);
      d.neg    = in_num[SAMPLE_BITS-1] ^ in_den[SAMPLE_BITS-1];
      d.num    = QUO_BITS'((n17[SAMPLE_BITS] ? -n17 : n17)) << FRAC_BITS;
      d.den    = d17[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-d17) : (SAMPLE_BITS+1)'(d17);
      st_in[0] = d;
   end

   for (genvar g = 0; g < NST; g++) begin : g_st
      always_comb begin
         div_type d;
         logic [QUO_BITS:0] t;
         d = st_ff[g];
         t = '0;
         for (int k = 0; k < PER; k++) begin
            if (g*PER + k < STEPS) begin
               t = {d.rem, d.num[QUO_BITS-1]};
               d.num = {d.num[QUO_BITS-2:0], 1'b0};
               if (t >= (QUO_BITS+1)'(d.den)) begin
                  t = t - (QUO_BITS+1)'(d.den);
                  d.quo = {d.quo[QUO_BITS-2:0], 1'b1};
               end else begin
                  d.quo = {d.quo[QUO_BITS-2:0], 1'b0};
               end
               d.rem = t[QUO_BITS-1:0];
            end
         end
         st_in[g+1] = d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[NST-1:0], in_valid};
      end
      for (int i = 0; i <= NST; i++) begin
         st_ff[i] <= st_in[i];
      end
   end

   always_comb begin
      logic signed [63:0] q;
      logic o;
      q = $signed(64'(st_ff[NST].quo));
      if (st_ff[NST].neg) begin
         q = -q;
      end
      out_quo   = sat_wide(q, o);
      out_ovf   = o & ~st_ff[NST].zero_w;
      out_zero  = st_ff[NST].zero_w;
      out_valid = vld_ff[NST];
   end
endmodule
`default_nettype wire

/* rtl/core/xcss_chan.sv */
// xcss_chan: chroma scaling tail of one channel, after the quotient
// depends on xcss_pkg
`timescale 1ns / 1ps
`default_nettype none
module xcss_chan import xcss_pkg::*; (
   input  wire logic       clock,
   input  wire sample_type c_in,
   input  wire sample_type y_in,
   input  wire sample_type s_in,
   input  wire sample_type w_in,
   input  wire sample_type q_in,
   input  wire logic       zero_in,
   input  wire logic       ovf_in,
   output sample_type      r_out,
   output logic            flag_out
);
   // stage a: d = q - y
   sample_type d_ff, y_a_ff, s_a_ff, w_a_ff, c_a_ff;
   logic       z_a_ff, f_a_ff;
   // stage b: product d*s
   logic signed [2*SAMPLE_BITS-1:0] p_ff;
   sample_type y_b_ff, w_b_ff, c_b_ff;
   logic       z_b_ff, f_b_ff;
   // stage c: e
   sample_type e_ff, w_c_ff, c_c_ff;
   logic       z_c_ff, f_c_ff;
   // stage d: product e*w
   logic signed [2*SAMPLE_BITS-1:0] m_ff;
   sample_type c_d_ff;
   logic       z_d_ff, f_d_ff;
   sample_type r_ff;
   logic       rf_ff;

   sample_type d_in, e_in, r_in;
   logic       od, oe, or_;

   always_comb begin
      d_in = sat_wide(64'(q_in) - 64'(y_in), od);
      e_in = sat_wide(64'(p_ff >>> FRAC_BITS) + 64'(y_b_ff), oe);
      r_in = sat_wide(64'(m_ff >>> FRAC_BITS), or_);
   end

   always_ff @(posedge clock) begin
      d_ff <= d_in; y_a_ff <= y_in; s_a_ff <= s_in; w_a_ff <= w_in; c_a_ff <= c_in;
      z_a_ff <= zero_in; f_a_ff <= ovf_in | od;
      p_ff <= d_ff * s_a_ff; y_b_ff <= y_a_ff; w_b_ff <= w_a_ff; c_b_ff <= c_a_ff;
      z_b_ff <= z_a_ff; f_b_ff <= f_a_ff;
      e_ff <= e_in; w_c_ff <= w_b_ff; c_c_ff <= c_b_ff; z_c_ff <= z_b_ff;
      f_c_ff <= f_b_ff | oe;
      m_ff <= e_ff * w_c_ff; c_d_ff <= c_c_ff; z_d_ff <= z_c_ff; f_d_ff <= f_c_ff;
      // zero white passes the channel through and flags
      r_ff  <= z_d_ff ? c_d_ff : r_in;
      rf_ff <= z_d_ff | f_d_ff | or_;
   end

   assign r_out    = r_ff;
   assign flag_out = rf_ff;
endmodule
`default_nettype wire

/* rtl/core/xyz_chroma_saturation_scale_core.sv */
// xyz_chroma_saturation_scale_core: top level of the chroma saturation scaler
// depends on xcss_pkg, xcss_div, xcss_chan
//
// channel   ports          handshake
// req       req_*          beat taken when start && !busy
// rsp       rsp_*          beat shown one cycle under rsp_valid
// csr       csr_*          write when csr_write
//
// one pixel per clock through the gain stage, divider and scale tail registers
// gain stage 1, divider 9 (input register plus 8 stages of up to 4 steps), scale tail 5
// a beat taken on start && !busy is strobed on rsp_* as it leaves the last scale tail register
// busy is tied low: the pipeline never stalls, the receiver cannot stall
// reset is synchronous; it clears valid bits and sets the CSR registers to their reset values; payload is not reset
`timescale 1ns / 1ps
`default_nettype none
module xyz_chroma_saturation_scale_core import xcss_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire sample_type            req_col_x,
   input  wire sample_type            req_col_y,
   input  wire sample_type            req_col_z,
   input  wire sample_type            req_col_alpha,
   input  wire sample_type            req_sat_white_x,
   input  wire sample_type            req_sat_gain,
   input  wire sample_type            req_sat_white_z,
   input  wire sample_type            req_sat_alpha,
   input  wire logic                  req_last_pixel,
   output logic                       rsp_valid,
   output sample_type                 rsp_out_x,
   output sample_type                 rsp_out_y,
   output sample_type                 rsp_out_z,
   output sample_type                 rsp_out_alpha,
   output logic                       rsp_range_flag,
   output logic                       rsp_last_out,
   input  wire logic                  csr_write,
   input  wire logic [1:0]            csr_index,
   input  wire logic [WHITE_BITS-1:0] csr_data
);
   localparam int DIV_LAT = DIV_STAGES + 1;
   localparam int TAIL    = 5;
   localparam int LAT     = 1 + DIV_LAT + TAIL;

   logic                  use_pw_ff;
   logic [WHITE_BITS-1:0] wx_ff, wz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_pw_ff <= 1'b0;
         wx_ff     <= WHITE_X_RESET;
         wz_ff     <= WHITE_Z_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_USE_PIXEL_WHITE: use_pw_ff <= csr_data[0];
            CSR_WHITE_X:         wx_ff     <= csr_data;
            CSR_WHITE_Z:         wz_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;
   logic take;
   assign take = start & ~busy;

   // stage 0: gain product and white point select
   logic signed [2*SAMPLE_BITS-1:0] g_ff;
   sample_type x0_ff, y0_ff, z0_ff, a0_ff, wx0_ff, wz0_ff;
   logic l0_ff, v0_ff;
   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else       v0_ff <= take;
      g_ff  <= req_sat_gain * req_sat_alpha;
      x0_ff <= req_col_x; y0_ff <= req_col_y; z0_ff <= req_col_z;
      a0_ff <= req_col_alpha; l0_ff <= req_last_pixel;
      wx0_ff <= use_pw_ff ? req_sat_white_x : sample_type'({1'b0, wx_ff});
      wz0_ff <= use_pw_ff ? req_sat_white_z : sample_type'({1'b0, wz_ff});
   end

   sample_type s_v;
   logic       s_ovf;
   always_comb s_v = sat_wide(64'(g_ff >>> FRAC_BITS), s_ovf);

   // dividers, one per chroma channel
   logic dvx, dvz, zx, zz, ox, oz;
   sample_type qx, qz;
   xcss_div u_div_x (.clock, .reset, .in_valid(v0_ff), .in_num(x0_ff), .in_den(wx0_ff),
      .out_valid(dvx), .out_zero(zx), .out_ovf(ox), .out_quo(qx));
   xcss_div u_div_z (.clock, .reset, .in_valid(v0_ff), .in_num(z0_ff), .in_den(wz0_ff),
      .out_valid(dvz), .out_zero(zz), .out_ovf(oz), .out_quo(qz));

   // side delay line for the operands the tail still needs
   typedef struct packed {
      sample_type x, y, z, a, wx, wz, s;
      logic sf, l;
   } side_type;
   side_type side_ff [DIV_LAT];
   always_ff @(posedge clock) begin
      side_ff[0] <= '{x:x0_ff, y:y0_ff, z:z0_ff, a:a0_ff, wx:wx0_ff, wz:wz0_ff,
                      s:s_v, sf:s_ovf, l:l0_ff};
      for (int i = 1; i < DIV_LAT; i++) side_ff[i] <= side_ff[i-1];
   end
   side_type sd;
   assign sd = side_ff[DIV_LAT-1];

   sample_type rx, rz;
   logic fx, fz;
   xcss_chan u_chan_x (.clock, .c_in(sd.x), .y_in(sd.y), .s_in(sd.s), .w_in(sd.wx),
      .q_in(qx), .zero_in(zx), .ovf_in(ox), .r_out(rx), .flag_out(fx));
   xcss_chan u_chan_z (.clock, .c_in(sd.z), .y_in(sd.y), .s_in(sd.s), .w_in(sd.wz),
      .q_in(qz), .zero_in(zz), .ovf_in(oz), .r_out(rz), .flag_out(fz));

   // pass-through fields ride along with the tail
   side_type tail_ff [TAIL];
   logic [TAIL-1:0] tv_ff;
   always_ff @(posedge clock) begin
      if (reset) tv_ff <= '0;
      else       tv_ff <= {tv_ff[TAIL-2:0], dvx};
      tail_ff[0] <= sd;
      for (int i = 1; i < TAIL; i++) tail_ff[i] <= tail_ff[i-1];
   end

   assign rsp_valid      = tv_ff[TAIL-1];
   assign rsp_out_x      = rx;
   assign rsp_out_z      = rz;
   assign rsp_out_y      = tail_ff[TAIL-1].y;
   assign rsp_out_alpha  = tail_ff[TAIL-1].a;
   assign rsp_last_out   = tail_ff[TAIL-1].l;
   assign rsp_range_flag = fx | fz | tail_ff[TAIL-1].sf;

   // both divider lanes must stay in lockstep
   a_lanes: assert property (@(posedge clock) disable iff (reset) dvx == dvz)
      else $error("divider lanes out of step");
   // every strobed result beat must match a beat taken earlier
   a_lat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(take, LAT))
      else $error("result without matching request");
   a_busy: assert property (@(posedge clock) !busy)
      else $error("pipeline stalled");
endmodule
`default_nettype wire

/* tb/xyz_chroma_saturation_scale_core_tb.sv */
// testbench for the chroma saturation scaler: directed and random pixels checked
// against an in-bench predictor; depends on xcss_pkg and xyz_chroma_saturation_scale_core
`timescale 1ns / 1ps
`default_nettype none

// one expected result beat
typedef struct {
   logic signed [15:0] x;
   logic signed [15:0] y;
   logic signed [15:0] z;
   logic signed [15:0] alpha;
   logic               flag;
   logic               last;
} pixel_result_type;

class pixel_scoreboard;
   pixel_result_type pending[$];
   int            errors;
   bit            use_pixel_white;
   longint        white_x;
   longint        white_z;

   function new();
      errors          = 0;
      use_pixel_white = 0;
      white_x         = 3893;
      white_z         = 4460;
   endfunction

   // clamp to the sample range, noting overflow
   function longint clip(longint v, ref bit flag);
      if (v > 32767) begin
         flag = 1;
         return 32767;
      end
      if (v < -32768) begin
         flag = 1;
         return -32768;
      end
      return v;
   endfunction

   // >>> on longint is arithmetic (floor)
   function longint shr(longint v);
      return v >>> 12;
   endfunction

   function longint rescale(longint c, longint y, longint s, longint w, ref bit flag);
      longint q, d, e;
      if (w == 0) begin
         flag = 1;
         return c;
      end
      q = clip((c * 4096) / w, flag);
      d = clip(q - y, flag);
      e = clip(shr(d * s) + y, flag);
      return clip(shr(e * w), flag);
   endfunction

   function void note_pixel(logic signed [15:0] cx, logic signed [15:0] cy,
                            logic signed [15:0] cz, logic signed [15:0] ca,
                            logic signed [15:0] wxp, logic signed [15:0] g,
                            logic signed [15:0] wzp, logic signed [15:0] ga,
                            logic last);
      pixel_result_type r;
      bit     flag;
      longint wx, wz, s;
      flag = 0;
      wx = use_pixel_white ? longint'(wxp) : white_x;
      wz = use_pixel_white ? longint'(wzp) : white_z;
      s  = clip(shr(longint'(g) * longint'(ga)), flag);
      r.x     = 16'(rescale(cx, cy, s, wx, flag));
      r.z     = 16'(rescale(cz, cy, s, wz, flag));
      r.y     = cy;
      r.alpha = ca;
      r.flag  = flag;
      r.last  = last;
      pending.push_back(r);
   endfunction

   function void check_result(pixel_result_type got);
      pixel_result_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result beat x=%0d", $time, got.x);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (got.x !== e.x) begin
         $display("%0t: out_x expected %0d actual %0d", $time, e.x, got.x);
         errors++;
      end
      if (got.y !== e.y) begin
         $display("%0t: out_y expected %0d actual %0d", $time, e.y, got.y);
         errors++;
      end
      if (got.z !== e.z) begin
         $display("%0t: out_z expected %0d actual %0d", $time, e.z, got.z);
         errors++;
      end
      if (got.alpha !== e.alpha) begin
         $display("%0t: out_alpha expected %0d actual %0d", $time, e.alpha, got.alpha);
         errors++;
      end
      if (got.flag !== e.flag) begin
         $display("%0t: range_flag expected %0b actual %0b", $time, e.flag, got.flag);
         errors++;
      end
      if (got.last !== e.last) begin
         $display("%0t: last_out expected %0b actual %0b", $time, e.last, got.last);
         errors++;
      end
   endfunction
endclass

module xyz_chroma_saturation_scale_core_tb;
   import xcss_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   sample_type req_col_x = '0, req_col_y = '0, req_col_z = '0, req_col_alpha = '0;
   sample_type req_sat_white_x = '0, req_sat_gain = '0, req_sat_white_z = '0;
   sample_type req_sat_alpha = '0;
   logic req_last_pixel = 0;
   logic rsp_valid;
   sample_type rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_alpha;
   logic rsp_range_flag, rsp_last_out;
   logic csr_write = 0;
   logic [1:0] csr_index = CSR_USE_PIXEL_WHITE;
   logic [WHITE_BITS-1:0] csr_data = '0;

   pixel_scoreboard board = new();
   int burst_left = 0;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   xyz_chroma_saturation_scale_core DUT (.*);

   // result side: the receiver cannot stall, so every strobed beat is checked
   always @(posedge clock) begin
      pixel_result_type got;
      if (!reset && rsp_valid === 1'b1) begin
         got.x = rsp_out_x;   got.y = rsp_out_y;
         got.z = rsp_out_z;   got.alpha = rsp_out_alpha;
         got.flag = rsp_range_flag;   got.last = rsp_last_out;
         board.check_result(got);
      end
   end

   // register write while idle; predictor copy updated at the same edge
   task automatic write_reg(logic [1:0] idx, logic [WHITE_BITS-1:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 0;
      case (idx)
         CSR_USE_PIXEL_WHITE: board.use_pixel_white = val[0];
         CSR_WHITE_X:         board.white_x = val;
         CSR_WHITE_Z:         board.white_z = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // one pixel beat; start held through a burst, gaps between bursts at random
   task automatic send_pixel(sample_type cx, sample_type cy, sample_type cz, sample_type ca,
                             sample_type wx, sample_type g, sample_type wz, sample_type ga,
                             logic last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 4);
         if (gap != 0) begin
            start <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      start <= 1;
      req_col_x <= cx;        req_col_y <= cy;
      req_col_z <= cz;        req_col_alpha <= ca;
      req_sat_white_x <= wx;  req_sat_gain <= g;
      req_sat_white_z <= wz;  req_sat_alpha <= ga;
      req_last_pixel <= last;
      do @(posedge clock); while (busy !== 1'b0);
      board.note_pixel(cx, cy, cz, ca, wx, g, wz, ga, last);
      burst_left--;
   endtask

   task automatic send_random(int n);
      sample_type v[8];
      for (int i = 0; i < n; i++) begin
         foreach (v[k]) v[k] = 16'($urandom);
         // mostly moderate values so the chroma math stays in range
         if ($urandom_range(0, 3) != 0) begin
            v[0] = 16'($signed($urandom_range(0, 16383)) - 8192);
            v[1] = 16'($signed($urandom_range(0, 16383)) - 8192);
            v[2] = 16'($signed($urandom_range(0, 16383)) - 8192);
            v[4] = 16'($urandom_range(1, 8191));
            v[6] = 16'($urandom_range(1, 8191));
            v[5] = 16'($signed($urandom_range(0, 16383)) - 4096);
            v[7] = 16'($urandom_range(0, 4096));
         end
         if ($urandom_range(0, 15) == 0) v[4] = '0;
         if ($urandom_range(0, 15) == 0) v[6] = '0;
         send_pixel(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], 1'($urandom));
      end
   endtask

   // wait for all expected beats, then pipeline drain time
   task automatic drain();
      start <= 0;
      burst_left = 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset white point registers and field extremes
      send_pixel(16'sh1000, 16'sh1000, 16'sh1000, 16'sh1000, '0, 16'sh1000, '0, 16'sh1000,
                 1'b0);
      send_pixel(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff,
                 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
      send_pixel(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
                 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
      send_pixel(16'sh0800, 16'sh0400, 16'sh0c00, 16'shffff, '0, 16'sh2000, '0, 16'sh1000,
                 1'b1);
      send_pixel('0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
      send_pixel(16'shffff, 16'shffff, 16'shffff, 16'sh0, 16'shffff, 16'shffff,
                 16'shffff, 16'shffff, 1'b1);
      drain();

      // per-pixel white: zero, negative and extreme whites
      write_reg(CSR_USE_PIXEL_WHITE, 15'd1);
      send_pixel(16'sh1000, 16'sh0800, 16'sh1000, 16'sh1000, '0, 16'sh1000, 16'sh1000,
                 16'sh1000, 1'b0);
      send_pixel(16'sh1000, 16'sh0800, 16'sh1000, 16'sh1000, 16'shf000, 16'sh1800,
                 '0, 16'sh1000, 1'b1);
      send_pixel(16'sh7fff, 16'sh0000, 16'sh8000, 16'sh1000, 16'sh0001, 16'sh1000,
                 16'sh0001, 16'sh1000, 1'b0);
      send_pixel(16'sh0100, 16'sh0200, 16'sh0300, 16'sh1000, 16'sh8000, 16'sh7fff,
                 16'sh7fff, 16'sh7fff, 1'b1);
      send_pixel(16'sh0f3d, 16'sh1000, 16'sh116c, 16'sh1000, 16'sh0f35, 16'sh0000,
                 16'sh116c, 16'sh1000, 1'b0);
      send_random(100);
      drain();

      // register white extremes, covering every bit of the white registers
      write_reg(CSR_USE_PIXEL_WHITE, 15'd0);
      write_reg(CSR_WHITE_X, 15'd1);
      write_reg(CSR_WHITE_Z, 15'd32767);
      send_random(90);
      drain();
      write_reg(CSR_WHITE_X, 15'd32767);
      write_reg(CSR_WHITE_Z, 15'd1);
      send_random(90);
      drain();
      write_reg(CSR_WHITE_X, 15'h2aaa);
      write_reg(CSR_WHITE_Z, 15'h5555);
      send_random(80);
      drain();
      write_reg(CSR_WHITE_X, 15'd3893);
      write_reg(CSR_WHITE_Z, 15'd4460);
      send_random(80);
      drain();

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("PASS xyz_chroma_saturation_scale_core");
      end else begin
         $display("FAIL xyz_chroma_saturation_scale_core");
      end
      $finish;
   end

   // timeout guard
   initial begin
      #2000000;
      $display("FAIL xyz_chroma_saturation_scale_core");
      $finish;
   end
endmodule
`default_nettype wire
